// File: rtl/ebml_fd_pkg.sv
// EBML field decoder: shared widths, field kind and status codes, result type
// and the VINT length helper. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ebml_fd_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    localparam logic [KIND_W-1:0] KIND_ID    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SIZE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VINT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SVINT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UINT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SINT  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_PAYLOAD  = 2'd3;

    localparam logic [COUNT_W-1:0] ID_MAX_LEN   = 4'd4;
    localparam logic [COUNT_W-1:0] VINT_MAX_LEN = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 4'd15;

    localparam logic [VALUE_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_VINT    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  byte_count;
    } result_t;

    // Leading zeroes plus one; nine for a zero byte
    function automatic logic [COUNT_W-1:0] vint_len(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] n;
        n = 4'd9;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (b[i])
            begin
                n = COUNT_W'(BYTE_W - i);
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/ebml_fd_if.sv
// EBML field decoder: valid/ready channel interfaces for input bytes and
// decoded fields. Depends on ebml_fd_pkg.
`timescale 1ns / 1ps

interface ebml_fd_in_if;
    import ebml_fd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface ebml_fd_out_if;
    import ebml_fd_pkg::*;

    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  byte_count;

    modport source (output valid, output value, output status, output byte_count,
                    input ready);
    modport sink   (input valid, input value, input status, input byte_count,
                    output ready);
endinterface

// File: rtl/ebml_fd_core.sv
// EBML field decoder datapath: field state registers, VINT length decode,
// byte accumulation and completion of a field. Depends on ebml_fd_pkg.
`timescale 1ns / 1ps

module ebml_fd_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [ebml_fd_pkg::KIND_W-1:0]   kind,
    input  logic [ebml_fd_pkg::BYTE_W-1:0]   data_byte,
    output logic                             res_valid,
    output ebml_fd_pkg::result_t             res
);
    import ebml_fd_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   mlen_reg, mlen_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;

    logic                 in_idle;
    logic                 kind_ok;
    logic [COUNT_W-1:0]   first_len;
    logic                 first_too_long;
    logic [VALUE_W-1:0]   first_acc;
    logic [VALUE_W-1:0]   acc_sh;
    logic [COUNT_W-1:0]   count_inc;
    logic [COUNT_W-1:0]   rem_dec;

    logic [VALUE_W-1:0]   fin_acc;
    logic [KIND_W-1:0]    fin_kind;
    logic [COUNT_W-1:0]   fin_len;
    logic [COUNT_W-1:0]   fin_count;
    logic [6:0]           fin_bits;
    logic [VALUE_W-1:0]   size_mask;
    logic [VALUE_W-1:0]   bias;
    logic                 fin_is_int;
    logic                 fin_to_payload;
    logic                 do_finish;

    logic [5:0]           sign_idx;
    logic                 pay_ext;
    logic [VALUE_W-1:0]   pay_val;

    assign in_idle        = (phase_reg == PH_IDLE);
    assign kind_ok        = (kind <= KIND_SINT);
    assign first_len      = vint_len(data_byte);
    assign first_too_long = first_len > ((kind == KIND_ID) ? ID_MAX_LEN : VINT_MAX_LEN);
    assign first_acc      = (kind == KIND_ID) ? VALUE_W'(data_byte)
                          : VALUE_W'(data_byte & (8'hFF >> first_len));
    assign acc_sh         = {acc_reg[VALUE_W-BYTE_W-1:0], data_byte};
    assign count_inc      = (count_reg != COUNT_MAX) ? count_reg + 4'd1 : count_reg;
    assign rem_dec        = (rem_reg != '0) ? rem_reg - 4'd1 : '0;

    // A VINT ends either on its first byte (length one) or on its last byte
    assign fin_acc   = in_idle ? first_acc : acc_sh;
    assign fin_kind  = in_idle ? kind : kind_reg;
    assign fin_len   = in_idle ? first_len : mlen_reg;
    assign fin_count = in_idle ? 4'd1 : count_inc;

    assign fin_bits   = ({3'd0, fin_len} << 3) - {3'd0, fin_len};
    assign size_mask  = ~(ALL_ONES << fin_bits[5:0]);
    assign bias       = size_mask >> 1;
    assign fin_is_int = (fin_kind inside {KIND_UINT, KIND_SINT});
    assign fin_to_payload = fin_is_int && (fin_acc != '0) && (fin_acc <= 64'd8);

    assign do_finish = accept &&
        ((in_idle && kind_ok && !first_too_long && (first_len == 4'd1)) ||
         ((phase_reg == PH_VINT) && (rem_dec == '0)));

    // Sign bit of an n-byte payload sits at 8n-1
    assign sign_idx = {mlen_reg[2:0] - 3'd1, 3'b111};
    assign pay_ext  = (kind_reg == KIND_SINT) && (mlen_reg != '0) &&
                      (mlen_reg < VINT_MAX_LEN) && acc_sh[sign_idx];
    assign pay_val  = pay_ext ? (acc_sh | (ALL_ONES << {mlen_reg[2:0], 3'b000})) : acc_sh;

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        rem_next   = rem_reg;
        mlen_next  = mlen_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (kind_ok)
                    begin
                        count_next = 4'd1;
                        if (!first_too_long)
                        begin
                            kind_next  = kind;
                            mlen_next  = first_len;
                            acc_next   = first_acc;
                            rem_next   = first_len - 4'd1;
                            phase_next = PH_VINT;
                        end
                    end
                end
                PH_VINT:
                begin
                    acc_next   = acc_sh;
                    count_next = count_inc;
                    rem_next   = rem_dec;
                end
                PH_PAYLOAD:
                begin
                    acc_next   = pay_val;
                    count_next = count_inc;
                    rem_next   = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
            if (do_finish)
            begin
                phase_next = PH_IDLE;
                if (fin_to_payload)
                begin
                    mlen_next  = fin_acc[COUNT_W-1:0];
                    rem_next   = fin_acc[COUNT_W-1:0];
                    acc_next   = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_comb
    begin
        res_valid      = 1'b0;
        res.value      = '0;
        res.status     = STATUS_OK;
        res.byte_count = fin_count;
        if (accept)
        begin
            if (in_idle && kind_ok && first_too_long)
            begin
                res_valid  = 1'b1;
                res.status = STATUS_TOO_LONG;
            end
            else if (do_finish)
            begin
                case (fin_kind)
                    KIND_ID, KIND_VINT:
                    begin
                        res_valid = 1'b1;
                        res.value = fin_acc;
                    end
                    KIND_SIZE:
                    begin
                        res_valid = 1'b1;
                        if (fin_acc == size_mask)
                        begin
                            res.status = STATUS_UNKNOWN;
                        end
                        else
                        begin
                            res.value = fin_acc;
                        end
                    end
                    KIND_SVINT:
                    begin
                        res_valid = 1'b1;
                        res.value = fin_acc - bias;
                    end
                    default:
                    begin
                        // integer element: empty, oversize, or go on to payload
                        if (fin_acc == '0)
                        begin
                            res_valid = 1'b1;
                        end
                        else if (!fin_to_payload)
                        begin
                            res_valid  = 1'b1;
                            res.status = STATUS_PAYLOAD;
                        end
                    end
                endcase
            end
            else if ((phase_reg == PH_PAYLOAD) && (rem_dec == '0))
            begin
                res_valid = 1'b1;
                res.value = pay_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= '0;
            rem_reg   <= '0;
            mlen_reg  <= '0;
            count_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            rem_reg   <= rem_next;
            mlen_reg  <= mlen_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

// File: rtl/ebml_field_decoder_unit.sv
// EBML field decoder top level: input channel, decode core and a two-entry
// result register with skid. Depends on ebml_fd_pkg, ebml_fd_if, ebml_fd_core.
`timescale 1ns / 1ps
//
//  channel    dir  beat contents                     accepted when
//  byte_in    in   kind, data_byte                   valid && ready
//  field_out  out  value, status, byte_count         valid && ready
//
//  One byte per cycle while byte_in is ready; a field's result is registered
//  in the result register as its last byte is taken, or in the skid entry.
//  The result register plus a skid entry set the rate: byte_in stays ready
//  while one result waits and drops only when the skid entry is full too.
//  rst_n clears the field state and both result entries at once.

module ebml_field_decoder_unit (
    input logic          clk,
    input logic          rst_n,
    ebml_fd_in_if.sink   byte_in,
    ebml_fd_out_if.source field_out
);
    import ebml_fd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, skid_reg;
    logic    out_fire;
    logic    load_out, load_skid, out_from_skid;

    assign byte_in.ready = !skid_valid_reg;
    assign accept        = byte_in.valid && !skid_valid_reg;
    assign out_fire      = out_valid_reg && field_out.ready;

    ebml_fd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (byte_in.kind),
        .data_byte (byte_in.data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg)
        begin
            // input is held off here, so only drain the skid entry
            if (out_fire)
            begin
                load_out        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_from_skid ? skid_reg : res;
        end
        if (load_skid)
        begin
            skid_reg <= res;
        end
    end

    assign field_out.valid      = out_valid_reg;
    assign field_out.value      = out_reg.value;
    assign field_out.status     = out_reg.status;
    assign field_out.byte_count = out_reg.byte_count;

endmodule

// File: rtl/ebml_fd_checker.sv
// EBML field decoder port checker and its bind to the top level.
// Depends on ebml_fd_pkg and ebml_field_decoder_unit.
`timescale 1ns / 1ps

module ebml_fd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ebml_fd_pkg::VALUE_W-1:0]   value,
    input logic [ebml_fd_pkg::STATUS_W-1:0]  status,
    input logic [ebml_fd_pkg::COUNT_W-1:0]   byte_count
);
    import ebml_fd_pkg::*;

    // nothing leaves the block while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // with no result pending the skid entry must be empty, so bytes are taken
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // every field uses at least its first byte
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != '0))
        else $error("result with zero byte count");

    // error and unknown-size beats carry a zero value
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (value == '0))
        else $error("non-ok status with non-zero value");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(value) &&
                                       $stable(status) && $stable(byte_count)))
        else $error("stalled result changed");

endmodule

bind ebml_field_decoder_unit ebml_fd_checker u_ebml_fd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .out_valid  (field_out.valid),
    .out_ready  (field_out.ready),
    .value      (field_out.value),
    .status     (field_out.status),
    .byte_count (field_out.byte_count)
);

// File: bench/ebml_fd_field_checker.sv
// Field checker for the EBML field decoder bench: predicts each decoded field
// from the accepted byte beats and compares it with the field_out beats.
// Depends on ebml_fd_pkg and ebml_fd_if.
`timescale 1ns / 1ps

module ebml_fd_field_checker (
    input  logic    clk,
    input  logic    rst_n,
    ebml_fd_in_if   byte_in,
    ebml_fd_out_if  field_out,
    output int      mismatches,
    output int      waiting
);
    import ebml_fd_pkg::*;

    phase_t              ph;
    logic [KIND_W-1:0]   cur_kind;
    logic [COUNT_W-1:0]  left;
    logic [COUNT_W-1:0]  span;
    logic [COUNT_W-1:0]  taken;
    logic [VALUE_W-1:0]  acc;
    result_t             pending_fields[$];
    int                  errs;

    function automatic int lead_len(input logic [BYTE_W-1:0] b);
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (b[i])
            begin
                return BYTE_W - i;
            end
        end
        return 9;
    endfunction

    task automatic post_field(input logic [VALUE_W-1:0] v, input logic [STATUS_W-1:0] st);
        result_t r;
        r.value      = v;
        r.status     = st;
        r.byte_count = taken;
        pending_fields.push_back(r);
        ph = PH_IDLE;
    endtask

    // Length prefix complete: emit the VINT, or move on to the integer payload
    task automatic close_length();
        int bits;
        bits = 7 * int'(span);
        case (cur_kind)
            KIND_ID, KIND_VINT:
                post_field(acc, STATUS_OK);
            KIND_SIZE:
                if (acc == (ALL_ONES >> (64 - bits)))
                    post_field('0, STATUS_UNKNOWN);
                else
                    post_field(acc, STATUS_OK);
            KIND_SVINT:
                post_field(acc - ((64'd1 << (bits - 1)) - 64'd1), STATUS_OK);
            default:
                if (acc == '0)
                    post_field('0, STATUS_OK);
                else if (acc > 64'd8)
                    post_field('0, STATUS_PAYLOAD);
                else
                begin
                    span = acc[COUNT_W-1:0];
                    left = acc[COUNT_W-1:0];
                    acc  = '0;
                    ph   = PH_PAYLOAD;
                end
        endcase
    endtask

    task automatic decode_byte(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
        int len;
        int limit;
        int bits;
        if (ph == PH_IDLE)
        begin
            // spare kinds are dropped while idle
            if (k > KIND_SINT)
                return;
            len   = lead_len(b);
            limit = (k == KIND_ID) ? int'(ID_MAX_LEN) : int'(VINT_MAX_LEN);
            taken = 4'd1;
            if (len > limit)
            begin
                post_field('0, STATUS_TOO_LONG);
                return;
            end
            cur_kind = k;
            span     = COUNT_W'(len);
            acc      = (k == KIND_ID) ? VALUE_W'(b) : VALUE_W'(b & (8'hFF >> len));
            left     = COUNT_W'(len - 1);
            if (left == '0)
                close_length();
            else
                ph = PH_VINT;
        end
        else
        begin
            acc = {acc[VALUE_W-BYTE_W-1:0], b};
            if (taken != COUNT_MAX)
                taken = taken + 4'd1;
            if (left != '0)
                left = left - 4'd1;
            if (ph == PH_VINT)
            begin
                if (left == '0)
                    close_length();
            end
            else if (left == '0)
            begin
                bits = 8 * int'(span);
                if (cur_kind == KIND_SINT && span >= 4'd1 && span < 4'd8 && acc[bits - 1])
                    acc = acc | (ALL_ONES << bits);
                post_field(acc, STATUS_OK);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            ph       = PH_IDLE;
            cur_kind = KIND_ID;
            left     = '0;
            span     = '0;
            taken    = '0;
            acc      = '0;
            errs     = 0;
            pending_fields.delete();
            mismatches <= 0;
            waiting    <= 0;
        end
        else
        begin
            if (field_out.valid && field_out.ready)
            begin
                got.value      = field_out.value;
                got.status     = field_out.status;
                got.byte_count = field_out.byte_count;
                if (pending_fields.size() == 0)
                begin
                    $error("unexpected field beat: value %h status %0d byte_count %0d",
                           got.value, got.status, got.byte_count);
                    errs++;
                end
                else
                begin
                    want = pending_fields.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("value: expected %h, got %h", want.value, got.value);
                        errs++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.byte_count !== want.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, got.byte_count);
                        errs++;
                    end
                end
            end
            if (byte_in.valid && byte_in.ready)
                decode_byte(byte_in.kind, byte_in.data_byte);
            waiting    <= pending_fields.size();
            mismatches <= errs;
        end
    end

endmodule

// File: bench/ebml_field_decoder_unit_test.sv
// Bench top for the EBML field decoder: clock, reset, byte stimulus with
// random gaps, result back-pressure, watchdog and verdict.
// Depends on ebml_fd_pkg, ebml_fd_if, ebml_field_decoder_unit, ebml_fd_field_checker.
`timescale 1ns / 1ps

module ebml_field_decoder_unit_test;
    import ebml_fd_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    // kinds the block has no use for
    localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   waiting;
    int   sent = 0;
    int   stall = 0;
    bit   src_steady = 1'b0;
    bit   sink_steady = 1'b0;
    beat_t stream_q[$];

    ebml_fd_in_if  byte_in ();
    ebml_fd_out_if field_out ();

    ebml_field_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .field_out (field_out)
    );

    ebml_fd_field_checker field_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .field_out  (field_out),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    always #5 clk = ~clk;

    // Corner fields; continuation kinds are deliberately odd
    beat_t opening [0:20] = '{
        {KIND_ID, 8'h81},
        {KIND_ID, 8'h1A}, {KIND_SPARE7, 8'h45}, {KIND_SIZE, 8'hDF}, {KIND_SINT, 8'hA3},
        {KIND_ID, 8'h08},
        {KIND_SIZE, 8'h00},
        {KIND_SIZE, 8'hFF},
        {KIND_SIZE, 8'h7F}, {KIND_ID, 8'hFF},
        {KIND_VINT, 8'h80},
        {KIND_SVINT, 8'h80},
        {KIND_SVINT, 8'hFF},
        {KIND_SPARE7, 8'hFF},
        {KIND_SPARE6, 8'h00},
        {KIND_UINT, 8'h80},
        {KIND_UINT, 8'h89},
        {KIND_SINT, 8'h81}, {KIND_UINT, 8'h80},
        {KIND_UINT, 8'h81}, {KIND_SPARE6, 8'hFF}
    };

    task automatic send_beat(input beat_t bt);
        int gap;
        if (sent % 64 == 0)
            src_steady = ($urandom_range(0, 2) == 0);
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid     <= 1'b1;
        byte_in.kind      <= bt.kind;
        byte_in.data_byte <= bt.data;
        do @(posedge clk); while (!byte_in.ready);
        sent++;
    endtask

    // Hold the byte stream until every predicted field has been taken
    task automatic drain_results();
        byte_in.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    task automatic queue_vint(input logic [KIND_W-1:0] k, input int len,
                              input logic [VALUE_W-1:0] bits_in);
        logic [VALUE_W-1:0] word;
        word = (bits_in & ((64'd1 << (7 * len)) - 64'd1)) | (64'd1 << (7 * len));
        for (int i = len - 1; i >= 0; i--)
            stream_q.push_back({(i == len - 1) ? k : KIND_W'($urandom_range(0, 7)),
                                word[8 * i +: 8]});
    endtask

    task automatic queue_field();
        int pick;
        int len;
        int n;
        logic [KIND_W-1:0]  k;
        logic [VALUE_W-1:0] bits;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       bits = '0;
            1:       bits = ALL_ONES;
            default: bits = {$urandom, $urandom};
        endcase
        if (pick < 12)
            queue_vint(KIND_ID, $urandom_range(1, 4), bits);
        else if (pick < 26)
        begin
            if ($urandom_range(0, 3) == 0)
                bits = ALL_ONES;
            queue_vint(KIND_SIZE, $urandom_range(1, 8), bits);
        end
        else if (pick < 38)
            queue_vint(KIND_VINT, $urandom_range(1, 8), bits);
        else if (pick < 50)
            queue_vint(KIND_SVINT, $urandom_range(1, 8), bits);
        else if (pick < 82)
        begin
            k = (pick < 66) ? KIND_UINT : KIND_SINT;
            if ($urandom_range(0, 11) == 0)
            begin
                // longest element: count saturates
                len = 8;
                n   = 8;
            end
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 1;
                n   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 127)
                                                  : $urandom_range(0, 8);
            end
            queue_vint(k, len, VALUE_W'(n));
            if (n <= 8)
                for (int i = 0; i < n; i++)
                    stream_q.push_back({KIND_W'($urandom_range(0, 7)), BYTE_W'($urandom)});
        end
        else if (pick < 90)
        begin
            k = KIND_W'($urandom_range(0, 5));
            if (k == KIND_ID)
                stream_q.push_back({k, 8'hFF >> $urandom_range(4, 8)});
            else
                stream_q.push_back({k, 8'h00});
        end
        else
            stream_q.push_back({KIND_W'($urandom_range(0, 7)), BYTE_W'($urandom)});
    endtask

    initial
    begin
        bit paused;
        paused            = 1'b0;
        byte_in.valid     <= 1'b0;
        byte_in.kind      <= KIND_ID;
        byte_in.data_byte <= '0;
        rst_n             <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[idx])
            send_beat(opening[idx]);
        drain_results();

        while (sent < ITEM_TARGET)
        begin
            if (!paused && sent >= ITEM_TARGET / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            queue_field();
            while (stream_q.size() != 0)
                send_beat(stream_q.pop_front());
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, with steady stretches now and then
    initial
    begin
        int gap;
        int taken;
        taken = 0;
        field_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 64 == 0)
                sink_steady = ($urandom_range(0, 2) == 0);
            gap = sink_steady ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                field_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            field_out.ready <= 1'b1;
            do @(posedge clk); while (!field_out.valid);
            taken++;
        end
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (byte_in.valid && byte_in.ready)
            || (field_out.valid && field_out.ready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/ebml_fd_pkg.sv
rtl/ebml_fd_if.sv
rtl/ebml_fd_core.sv
rtl/ebml_field_decoder_unit.sv
rtl/ebml_fd_checker.sv
bench/ebml_fd_field_checker.sv
bench/ebml_field_decoder_unit_test.sv
